@@ hdl/rcfd_pkg.sv @@
package rcfd_pkg;

  localparam int DBUS_LEN    = 18;
  localparam int SBUS_LEN    = 25;
  localparam int RX_BUF      = 36;
  localparam int STORE_DEPTH = 25;

  localparam int IDX_W   = $clog2(STORE_DEPTH);
  localparam int CNT_W   = $clog2(RX_BUF + 1);
  localparam int AGE_W   = 17;
  localparam int CH_W    = 11;
  localparam int STICK_W = 12;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  localparam logic [10:0] OFFSET_RST    = 11'd1024;
  localparam logic [9:0]  DEADBAND_RST  = 10'd10;
  localparam logic [9:0]  THRESHOLD_RST = 10'd300;
  localparam logic [15:0] TIMEOUT_RST   = 16'd100;
  localparam logic [7:0]  HEADER_RST    = 8'd15;

  localparam logic signed [STICK_W-1:0] SBUS_INV_CENTER = 12'sd1023;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_IDLE = 2'd1,
    CMD_TICK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    SRC_DBUS    = 2'd0,
    SRC_SBUS    = 2'd1,
    SRC_TIMEOUT = 2'd2
  } src_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_OFFSET    = 3'd0,
    REG_DEADBAND  = 3'd1,
    REG_THRESHOLD = 3'd2,
    REG_TIMEOUT   = 3'd3,
    REG_HEADER    = 3'd4
  } reg_e;

  localparam logic [1:0] SW_UP   = 2'd1;
  localparam logic [1:0] SW_DOWN = 2'd2;
  localparam logic [1:0] SW_MID  = 2'd3;

  localparam logic [7:0] SBUS_SW_SAFE = 8'hAA;
  localparam logic [3:0] DBUS_SW_SAFE = 4'hA;

  // last field in the lowest bits
  typedef struct packed {
    logic [15:0]                key_bits;
    logic [15:0]                mouse_buttons;
    logic [47:0]                mouse_xyz;
    logic signed [15:0]         wheel;
    logic [3:0]                 dbus_switches;
    logic [7:0]                 sbus_switches;
    logic signed [STICK_W-1:0]  stick_3;
    logic signed [STICK_W-1:0]  stick_2;
    logic signed [STICK_W-1:0]  stick_1;
    logic signed [STICK_W-1:0]  stick_0;
  } rec_t;

  typedef struct packed {
    src_e source;
    rec_t rec;
  } res_t;

  localparam int REC_W     = $bits(rec_t);
  localparam int TDATA_W   = ((REC_W + 7) / 8) * 8;
  localparam int TDATA_PAD = TDATA_W - REC_W;

  function automatic logic signed [STICK_W-1:0] centered(input logic [CH_W-1:0] raw,
                                                         input logic [10:0] offset);
    return $signed({1'b0, raw}) - $signed({1'b0, offset});
  endfunction

  function automatic logic signed [STICK_W-1:0] inverted(input logic [CH_W-1:0] raw);
    return SBUS_INV_CENTER - $signed({1'b0, raw});
  endfunction

  function automatic logic signed [STICK_W-1:0] dead(input logic signed [STICK_W-1:0] v,
                                                     input logic [9:0] band);
    logic signed [STICK_W-1:0] d;
    d = $signed({2'b00, band});
    return (v <= d && v >= -d) ? '0 : v;
  endfunction

  function automatic logic [1:0] two_pos(input logic signed [STICK_W-1:0] v);
    return (v > 0) ? SW_DOWN : SW_UP;
  endfunction

  function automatic logic [1:0] three_pos(input logic signed [STICK_W-1:0] v,
                                           input logic [9:0] thr);
    logic signed [STICK_W-1:0] t;
    t = $signed({2'b00, thr});
    if (v > t) return SW_DOWN;
    if (v < -t) return SW_UP;
    return SW_MID;
  endfunction

endpackage

@@ hdl/rc_receiver_frame_decoder_core.sv @@
// rc receiver frame decoder
//
// s_axis carries one item per uart event: tuser is the command (received
// byte, idle line that ends a frame, millisecond tick), tdata the byte.
// an idle line after 18 bytes decodes a dbus frame, after 25 bytes with a
// matching header an sbus frame; other frames are dropped silently.
// a tick that finds the frame age above timeout_ms emits safe values.
// m_axis carries the whole held record, tuser says which source made it.
//
// a new item can be taken each cycle while s_axis_tready is high.
// a result goes to the output register, or to the skid entry while m_axis
// stalls; the decode is a single pass of subtract and compare per channel.
// a one-entry skid buffer behind the output register lets the input keep
// flowing while a result waits; s_axis_tready drops only when both hold a
// result, and rises again as soon as m_axis takes one.
// cfg_we writes register cfg_addr with cfg_wdata at once.
// reset clears the byte count, frame age and held record and loads the
// register defaults; frame byte storage is not cleared.
module rc_receiver_frame_decoder_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // rx_byte
  input  logic [1:0]                          s_axis_tuser,   // cmd
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // stick_0, stick_1, stick_2, stick_3, sbus_switches, dbus_switches, wheel,
  // mouse_xyz, mouse_buttons, key_bits, zero fill
  output logic [rcfd_pkg::TDATA_W-1:0]        m_axis_tdata,
  output logic [1:0]                          m_axis_tuser,   // source
  input  logic                                cfg_we,
  input  logic [rcfd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [rcfd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [10:0] channel_offset;
  logic [9:0]  stick_deadband;
  logic [9:0]  switch_threshold;
  logic [15:0] timeout_ms;
  logic [7:0]  sbus_header_byte;

  logic [7:0]                    frame_bytes [rcfd_pkg::STORE_DEPTH];
  logic [rcfd_pkg::CNT_W-1:0]    byte_count;
  logic [rcfd_pkg::AGE_W-1:0]    ms_since_frame;
  rcfd_pkg::rec_t                held;

  logic [8*rcfd_pkg::STORE_DEPTH-1:0] fbv;
  logic                          acc;
  logic                          res_fire;
  rcfd_pkg::res_t                res_next;
  logic [rcfd_pkg::AGE_W-1:0]    age_inc;

  logic                          out_valid;
  rcfd_pkg::res_t                out_res;
  logic                          skid_valid;
  rcfd_pkg::res_t                skid_res;
  logic                          out_free;

  assign s_axis_tready = !skid_valid;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.source;
  assign m_axis_tdata  = {{rcfd_pkg::TDATA_PAD{1'b0}}, out_res.rec};

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_offset   <= rcfd_pkg::OFFSET_RST;
      stick_deadband   <= rcfd_pkg::DEADBAND_RST;
      switch_threshold <= rcfd_pkg::THRESHOLD_RST;
      timeout_ms       <= rcfd_pkg::TIMEOUT_RST;
      sbus_header_byte <= rcfd_pkg::HEADER_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        rcfd_pkg::REG_OFFSET:    channel_offset   <= cfg_wdata[10:0];
        rcfd_pkg::REG_DEADBAND:  stick_deadband   <= cfg_wdata[9:0];
        rcfd_pkg::REG_THRESHOLD: switch_threshold <= cfg_wdata[9:0];
        rcfd_pkg::REG_TIMEOUT:   timeout_ms       <= cfg_wdata[15:0];
        rcfd_pkg::REG_HEADER:    sbus_header_byte <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < rcfd_pkg::STORE_DEPTH; i++) begin
      fbv[8*i +: 8] = frame_bytes[i];
    end
  end

  assign age_inc = (ms_since_frame == rcfd_pkg::AGE_MAX) ? ms_since_frame
                                                         : ms_since_frame + 1'b1;

  // decode: channels sit 11 bits apart, dbus from bit 0, sbus from bit 8
  always_comb begin
    res_fire        = 1'b0;
    res_next.source = rcfd_pkg::SRC_DBUS;
    res_next.rec    = held;
    if (acc) begin
      case (s_axis_tuser)
        rcfd_pkg::CMD_IDLE: begin
          if (byte_count == rcfd_pkg::CNT_W'(rcfd_pkg::DBUS_LEN)) begin
            res_fire = 1'b1;
            res_next.source = rcfd_pkg::SRC_DBUS;
            res_next.rec.stick_0 = rcfd_pkg::dead(
              rcfd_pkg::centered(fbv[0 +: 11], channel_offset), stick_deadband);
            res_next.rec.stick_1 = rcfd_pkg::dead(
              rcfd_pkg::centered(fbv[11 +: 11], channel_offset), stick_deadband);
            res_next.rec.stick_2 = rcfd_pkg::dead(
              rcfd_pkg::centered(fbv[22 +: 11], channel_offset), stick_deadband);
            res_next.rec.stick_3 = rcfd_pkg::dead(
              rcfd_pkg::centered(fbv[33 +: 11], channel_offset), stick_deadband);
            res_next.rec.dbus_switches = fbv[44 +: 4];
            res_next.rec.mouse_xyz     = fbv[48 +: 48];
            res_next.rec.mouse_buttons = fbv[96 +: 16];
            res_next.rec.key_bits      = fbv[112 +: 16];
            res_next.rec.wheel = $signed(fbv[128 +: 16] - {5'b0, channel_offset});
          end else if (byte_count == rcfd_pkg::CNT_W'(rcfd_pkg::SBUS_LEN)
                       && frame_bytes[0] == sbus_header_byte) begin
            res_fire = 1'b1;
            res_next.source = rcfd_pkg::SRC_SBUS;
            res_next.rec.stick_0 = rcfd_pkg::dead(
              rcfd_pkg::centered(fbv[8 +: 11], channel_offset), stick_deadband);
            // vertical sticks are mirrored about a fixed center
            res_next.rec.stick_1 = rcfd_pkg::dead(
              rcfd_pkg::inverted(fbv[19 +: 11]), stick_deadband);
            res_next.rec.stick_3 = rcfd_pkg::dead(
              rcfd_pkg::inverted(fbv[30 +: 11]), stick_deadband);
            res_next.rec.stick_2 = rcfd_pkg::dead(
              rcfd_pkg::centered(fbv[41 +: 11], channel_offset), stick_deadband);
            res_next.rec.sbus_switches = {
              rcfd_pkg::two_pos(rcfd_pkg::centered(fbv[85 +: 11], channel_offset)),
              rcfd_pkg::three_pos(rcfd_pkg::centered(fbv[74 +: 11], channel_offset),
                                  switch_threshold),
              rcfd_pkg::three_pos(rcfd_pkg::centered(fbv[63 +: 11], channel_offset),
                                  switch_threshold),
              rcfd_pkg::two_pos(rcfd_pkg::centered(fbv[52 +: 11], channel_offset))};
            res_next.rec.mouse_xyz     = '0;
            res_next.rec.mouse_buttons = '0;
            res_next.rec.key_bits      = '0;
          end
        end
        rcfd_pkg::CMD_TICK: begin
          if (age_inc > {1'b0, timeout_ms}) begin
            res_fire = 1'b1;
            res_next.source = rcfd_pkg::SRC_TIMEOUT;
            res_next.rec = '0;
            res_next.rec.sbus_switches = rcfd_pkg::SBUS_SW_SAFE;
            res_next.rec.dbus_switches = rcfd_pkg::DBUS_SW_SAFE;
          end
        end
        default: ;
      endcase
    end
  end

  // frame byte store, no reset
  always_ff @(posedge clk) begin
    if (acc && s_axis_tuser == rcfd_pkg::CMD_BYTE
        && byte_count < rcfd_pkg::CNT_W'(rcfd_pkg::STORE_DEPTH)) begin
      frame_bytes[byte_count[rcfd_pkg::IDX_W-1:0]] <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      ms_since_frame <= '0;
      held           <= '0;
    end else begin
      if (acc) begin
        case (s_axis_tuser)
          rcfd_pkg::CMD_BYTE: begin
            if (byte_count < rcfd_pkg::CNT_W'(rcfd_pkg::RX_BUF)) begin
              byte_count <= byte_count + 1'b1;
            end
          end
          rcfd_pkg::CMD_IDLE: begin
            byte_count <= '0;
            if (res_fire) begin
              ms_since_frame <= '0;
            end
          end
          rcfd_pkg::CMD_TICK: ms_since_frame <= age_inc;
          default: ;
        endcase
      end
      if (res_fire) begin
        held <= res_next.rec;
      end
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_fire;
      end
    end else if (res_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (res_fire) begin
        out_res <= res_next;
      end
    end else if (res_fire) begin
      skid_res <= res_next;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= rcfd_pkg::CNT_W'(rcfd_pkg::RX_BUF))
    else $error("byte count beyond buffer size");

  a_idle_clears_count: assert property (@(posedge clk) disable iff (rst)
    acc && s_axis_tuser == rcfd_pkg::CMD_IDLE |=> byte_count == '0)
    else $error("idle line did not clear byte count");

  a_frame_resets_age: assert property (@(posedge clk) disable iff (rst)
    acc && s_axis_tuser == rcfd_pkg::CMD_IDLE
    && byte_count == rcfd_pkg::CNT_W'(rcfd_pkg::DBUS_LEN) |=> ms_since_frame == '0)
    else $error("decoded frame did not reset frame age");

  a_timeout_safe: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.source == rcfd_pkg::SRC_TIMEOUT |->
      out_res.rec.stick_0 == '0 && out_res.rec.stick_3 == '0
      && out_res.rec.sbus_switches == rcfd_pkg::SBUS_SW_SAFE
      && out_res.rec.dbus_switches == rcfd_pkg::DBUS_SW_SAFE)
    else $error("timeout result without safe values");

endmodule

@@ dv/rc_receiver_frame_decoder_core_tb.sv @@
module rc_receiver_frame_decoder_core_tb;
  import rcfd_pkg::*;

  localparam logic [1:0] CMD_RSVD = 2'd3;  // no meaning, must be ignored
  localparam int RUN_LIMIT = 4_000_000;

  class rc_record_board;
    logic [10:0] offset;
    logic [9:0]  band;
    logic [9:0]  thr;
    logic [15:0] tmo;
    logic [7:0]  hdr;

    logic [7:0]       frame [STORE_DEPTH];
    int unsigned      nbytes;
    logic [AGE_W-1:0] age;
    rec_t             held;
    res_t             records_due[$];

    int errors;
    int n_dbus;
    int n_sbus;
    int n_safe;

    function void clear();
      offset = OFFSET_RST;
      band = DEADBAND_RST;
      thr = THRESHOLD_RST;
      tmo = TIMEOUT_RST;
      hdr = HEADER_RST;
      nbytes = 0;
      age = '0;
      held = '0;
      records_due.delete();
      errors = 0;
      n_dbus = 0;
      n_sbus = 0;
      n_safe = 0;
    endfunction

    function void write_reg(reg_e r, logic [15:0] v);
      case (r)
        REG_OFFSET:    offset = v[10:0];
        REG_DEADBAND:  band = v[9:0];
        REG_THRESHOLD: thr = v[9:0];
        REG_TIMEOUT:   tmo = v;
        REG_HEADER:    hdr = v[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return records_due.size();
    endfunction

    function int from_center(logic [10:0] raw);
      return int'(raw) - int'(offset);
    endfunction

    function logic signed [STICK_W-1:0] squash(int v);
      if (v <= int'(band) && v >= -int'(band)) return '0;
      return v[STICK_W-1:0];
    endfunction

    function logic [1:0] pick3(int v);
      if (v > int'(thr)) return SW_DOWN;
      if (v < -int'(thr)) return SW_UP;
      return SW_MID;
    endfunction

    function logic [10:0] slot(logic [87:0] w, int k);
      return w[11*k +: 11];
    endfunction

    function void unpack_dbus();
      logic [47:0] w;
      w = {frame[5], frame[4], frame[3], frame[2], frame[1], frame[0]};
      held.stick_0 = squash(from_center(w[10:0]));
      held.stick_1 = squash(from_center(w[21:11]));
      held.stick_2 = squash(from_center(w[32:22]));
      held.stick_3 = squash(from_center(w[43:33]));
      held.dbus_switches = w[47:44];
      held.wheel = {frame[17], frame[16]} - {5'b0, offset};
      held.mouse_xyz = {frame[11], frame[10], frame[9], frame[8], frame[7], frame[6]};
      held.mouse_buttons = {frame[13], frame[12]};
      held.key_bits = {frame[15], frame[14]};
    endfunction

    function void unpack_sbus();
      logic [87:0] w;
      logic [1:0]  sa, sb, sc, sd;
      for (int i = 0; i < 11; i++) w[8*i +: 8] = frame[i+1];
      // vertical sticks are mirrored around a fixed center, not the offset
      held.stick_0 = squash(from_center(slot(w, 0)));
      held.stick_1 = squash(int'(SBUS_INV_CENTER) - int'(slot(w, 1)));
      held.stick_2 = squash(from_center(slot(w, 3)));
      held.stick_3 = squash(int'(SBUS_INV_CENTER) - int'(slot(w, 2)));
      sa = (from_center(slot(w, 4)) > 0) ? SW_DOWN : SW_UP;
      sb = pick3(from_center(slot(w, 5)));
      sc = pick3(from_center(slot(w, 6)));
      sd = (from_center(slot(w, 7)) > 0) ? SW_DOWN : SW_UP;
      held.sbus_switches = {sd, sc, sb, sa};
      held.mouse_xyz = '0;
      held.mouse_buttons = '0;
      held.key_bits = '0;
    endfunction

    function void post(src_e s);
      res_t r;
      r.source = s;
      r.rec = held;
      records_due.push_back(r);
    endfunction

    function void absorb_event(logic [1:0] c, logic [7:0] b);
      int unsigned len;
      case (c)
        CMD_BYTE: begin
          if (nbytes < STORE_DEPTH) frame[nbytes] = b;
          if (nbytes < RX_BUF) nbytes++;
        end
        CMD_IDLE: begin
          len = nbytes;
          nbytes = 0;
          if (len == DBUS_LEN) begin
            unpack_dbus();
            age = '0;
            post(SRC_DBUS);
          end else if (len == SBUS_LEN && frame[0] == hdr) begin
            unpack_sbus();
            age = '0;
            post(SRC_SBUS);
          end
        end
        CMD_TICK: begin
          if (age != AGE_MAX) age++;
          if (age > tmo) begin
            held = '0;
            held.sbus_switches = SBUS_SW_SAFE;
            held.dbus_switches = DBUS_SW_SAFE;
            post(SRC_TIMEOUT);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task cmp(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_record(logic [1:0] src, logic [TDATA_W-1:0] data);
      res_t want;
      rec_t got;
      if (records_due.size() == 0) begin
        report($sformatf("record with source %0d but none due", src));
        return;
      end
      want = records_due.pop_front();
      got = data[REC_W-1:0];
      cmp("source", {62'b0, src}, {62'b0, want.source});
      cmp("stick_0", {52'b0, got.stick_0}, {52'b0, want.rec.stick_0});
      cmp("stick_1", {52'b0, got.stick_1}, {52'b0, want.rec.stick_1});
      cmp("stick_2", {52'b0, got.stick_2}, {52'b0, want.rec.stick_2});
      cmp("stick_3", {52'b0, got.stick_3}, {52'b0, want.rec.stick_3});
      cmp("sbus_switches", {56'b0, got.sbus_switches}, {56'b0, want.rec.sbus_switches});
      cmp("dbus_switches", {60'b0, got.dbus_switches}, {60'b0, want.rec.dbus_switches});
      cmp("wheel", {48'b0, got.wheel}, {48'b0, want.rec.wheel});
      cmp("mouse_xyz", {16'b0, got.mouse_xyz}, {16'b0, want.rec.mouse_xyz});
      cmp("mouse_buttons", {48'b0, got.mouse_buttons}, {48'b0, want.rec.mouse_buttons});
      cmp("key_bits", {48'b0, got.key_bits}, {48'b0, want.rec.key_bits});
      case (want.source)
        SRC_DBUS: n_dbus++;
        SRC_SBUS: n_sbus++;
        default:  n_safe++;
      endcase
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  rc_record_board sb;
  int  items_taken = 0;
  int  useful_items = 0;
  int  settings_done = 0;
  bit  idling = 1'b0;
  int  stall_left = 0;

  rc_receiver_frame_decoder_core DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // results are checked before the item of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_record(m_axis_tuser, m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) begin
        sb.absorb_event(s_axis_tuser, s_axis_tdata);
        items_taken++;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling && $urandom_range(0, 11) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_item(logic [1:0] c, logic [7:0] b);
    int want;
    want = items_taken + 1;
    if (idling && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= c;
    s_axis_tdata <= b;
    if (c != CMD_RSVD) useful_items++;
    while (items_taken != want) @(negedge clk);
  endtask

  // first < 0: first byte as the payload; fill < 0: random payload
  task automatic send_frame(int len, int first, int fill, bit mix);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (i == 0 && first >= 0) b = first[7:0];
      else if (fill >= 0) b = fill[7:0];
      else b = 8'($urandom_range(0, 255));
      send_item(CMD_BYTE, b);
      if (mix && $urandom_range(0, 19) == 0) send_item(CMD_TICK, 8'($urandom));
    end
    send_item(CMD_IDLE, 8'($urandom));
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(reg_e r, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= r;
    cfg_wdata <= v;
    @(negedge clk);
    sb.write_reg(r, v);
  endtask

  task automatic load_config(logic [15:0] o, logic [15:0] d, logic [15:0] t,
                             logic [15:0] tm, logic [15:0] h);
    settle();
    put_reg(REG_OFFSET, o);
    put_reg(REG_DEADBAND, d);
    put_reg(REG_THRESHOLD, t);
    put_reg(REG_TIMEOUT, tm);
    put_reg(REG_HEADER, h);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  function automatic int spread(int hi);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  task automatic load_random_config();
    int tm;
    case ($urandom_range(0, 5))
      0:       tm = 0;
      1:       tm = 32'hFFFF;
      default: tm = $urandom_range(0, 12);
    endcase
    load_config(16'(spread(2047)), 16'(spread(1023)), 16'(spread(1023)), 16'(tm),
                16'(spread(255)));
  endtask

  task automatic random_unit();
    int h;
    h = int'(sb.hdr);
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6:  send_frame(DBUS_LEN, -1, -1, 1'b1);
      7, 8, 9, 10, 11, 12:  send_frame(SBUS_LEN, h, -1, 1'b1);
      13: send_frame(SBUS_LEN, h ^ (1 << $urandom_range(0, 7)), -1, 1'b1);
      // includes overlong frames past the count limit
      14: send_frame($urandom_range(0, RX_BUF + 6), -1, -1, 1'b1);
      15, 16, 17: repeat ($urandom_range(1, 8)) send_item(CMD_TICK, 8'($urandom));
      18: send_item(CMD_RSVD, 8'($urandom));
      default: send_item(($urandom_range(0, 1) == 0) ? CMD_BYTE : CMD_IDLE, 8'($urandom));
    endcase
  endtask

  initial begin
    int stop_at;
    int phase;
    sb = new;
    sb.clear();
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    idling = 1'b1;

    send_frame(DBUS_LEN, -1, 8'hFF, 1'b0);
    send_frame(SBUS_LEN, int'(HEADER_RST), 8'h00, 1'b0);
    send_item(CMD_RSVD, 8'hFF);
    repeat (3) send_item(CMD_TICK, 8'h00);
    load_config(16'(OFFSET_RST), 16'(DEADBAND_RST), 16'(THRESHOLD_RST), 16'd1,
                16'(HEADER_RST));
    repeat (3) send_item(CMD_TICK, 8'hFF);

    stop_at = useful_items + 1050;
    phase = 0;
    while (useful_items < stop_at) begin
      idling = ($urandom_range(0, 3) != 0);
      case (phase)
        0:       load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        1:       load_config(16'd2047, 16'd1023, 16'd1023, 16'hFFFF, 16'd255);
        default: load_random_config();
      endcase
      repeat (10) random_unit();
      phase++;
    end

    idling = 1'b0;
    load_random_config();
    repeat (10) random_unit();
    settle();

    $display("run: %0d input items under %0d register settings, extreme settings included",
             items_taken, settings_done);
    $display("records checked: %0d dbus, %0d sbus, %0d safe", sb.n_dbus, sb.n_sbus,
             sb.n_safe);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
